// ===== design/tcch_pkg.sv =====
// shared types, constants and helper functions for the compass heading block
package tcch_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int STEP_W           = 5;
  localparam int RED_STEPS        = 5;
  localparam int MATH_OPS         = 12;
  localparam int AXES             = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 32;

  localparam logic signed [31:0] PI_RAW          = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_RAW     = 32'sd26353589;
  localparam logic signed [31:0] TWO_PI_RAW      = 32'sd105414357;
  localparam logic signed [31:0] CORDIC_GAIN_RAW = 32'sd10188012;
  localparam logic signed [16:0] LIMIT_HIGH      = 17'sd2047;
  localparam logic signed [16:0] LIMIT_LOW       = -17'sd2048;
  localparam logic [31:0]        INVALID_HEADING = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_MASK = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_AXIS,
    OP_RED_INIT,
    OP_RED_STEP,
    OP_FOLD,
    OP_ROT,
    OP_SAVE,
    OP_P_MXCP,
    OP_P_SRMY,
    OP_P_PRSP,
    OP_P_CRMZ,
    OP_P_MYCR,
    OP_P_MZSR,
    OP_HX_SET,
    OP_HX_ADD,
    OP_HY_SET,
    OP_HY_SUB,
    OP_VPREP,
    OP_VEC,
    OP_FINAL
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS,
    ST_RED_INIT,
    ST_RED,
    ST_FOLD,
    ST_ROT,
    ST_SAVE,
    ST_MATH,
    ST_VPREP,
    ST_VEC,
    ST_FINAL
  } state_e;

  typedef struct packed {
    dp_op_e            op;
    logic [STEP_W-1:0] step;
    logic              sel;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic zero_vec;
  } dp_stat_t;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd13176795;
      5'd1:    v = 32'd7778716;
      5'd2:    v = 32'd4110060;
      5'd3:    v = 32'd2086331;
      5'd4:    v = 32'd1047214;
      5'd5:    v = 32'd524117;
      5'd6:    v = 32'd262123;
      5'd7:    v = 32'd131069;
      5'd8:    v = 32'd65536;
      5'd9:    v = 32'd32768;
      5'd10:   v = 32'd16384;
      5'd11:   v = 32'd8192;
      5'd12:   v = 32'd4096;
      5'd13:   v = 32'd2048;
      5'd14:   v = 32'd1024;
      5'd15:   v = 32'd512;
      5'd16:   v = 32'd256;
      5'd17:   v = 32'd128;
      5'd18:   v = 32'd64;
      5'd19:   v = 32'd32;
      5'd20:   v = 32'd16;
      5'd21:   v = 32'd8;
      5'd22:   v = 32'd4;
      5'd23:   v = 32'd2;
      5'd24:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // tilt compensation sequence on the shared multiplier
  function automatic dp_op_e math_op(input logic [3:0] k);
    dp_op_e op;
    case (k)
      4'd0:    op = OP_P_MXCP;
      4'd1:    op = OP_HX_SET;
      4'd2:    op = OP_P_SRMY;
      4'd3:    op = OP_P_PRSP;
      4'd4:    op = OP_HX_ADD;
      4'd5:    op = OP_P_CRMZ;
      4'd6:    op = OP_P_PRSP;
      4'd7:    op = OP_HX_ADD;
      4'd8:    op = OP_P_MYCR;
      4'd9:    op = OP_HY_SET;
      4'd10:   op = OP_P_MZSR;
      4'd11:   op = OP_HY_SUB;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// ===== design/tcch_dp.sv =====
// datapath: config registers, axis scaling, cordic unit, multiplier and result registers
module tcch_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tcch_pkg::dp_cmd_t                   cmd_i,
  output tcch_pkg::dp_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [tcch_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcch_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                bus_ok_i,
  input  logic signed [15:0]                  count_x_i,
  input  logic signed [15:0]                  count_y_i,
  input  logic signed [15:0]                  count_z_i,
  input  logic signed [31:0]                  roll_angle_i,
  input  logic signed [31:0]                  pitch_angle_i,
  output logic signed [31:0]                  field_x_o,
  output logic signed [31:0]                  field_y_o,
  output logic signed [31:0]                  field_z_o,
  output logic signed [31:0]                  heading_angle_o,
  output logic                                sample_valid_o,
  output logic [2:0]                          saturated_axes_o
);

  logic [30:0]        gain_q;
  logic signed [31:0] ofs_q [tcch_pkg::AXES];
  logic signed [31:0] decl_q;
  logic [2:0]         neg_q;

  logic signed [31:0] fld_q [tcch_pkg::AXES];
  logic               bus_ok_q;
  logic [2:0]         sat_q;
  logic signed [11:0] cnt_q [tcch_pkg::AXES];
  logic signed [31:0] roll_q, pitch_q;

  logic [31:0]        m_q;
  logic               neg_a_q, flip_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic signed [31:0] sr_q, cr_q, sp_q, cp_q;
  logic signed [31:0] pr_q, hx_q, hy_q;

  logic signed [31:0] fx_out_q, fy_out_q, fz_out_q, head_out_q;
  logic               valid_out_q;
  logic [2:0]         sat_out_q;

  logic signed [15:0] cnt_in [tcch_pkg::AXES];
  logic signed [16:0] cnt_neg [tcch_pkg::AXES];
  logic [2:0]         oor;
  logic [1:0]         axis;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [39:0] prod_sh;
  logic signed [31:0] fm;
  logic signed [31:0] axis_sum;
  logic signed [31:0] ang;
  logic [2:0]         red_sh;
  logic [31:0]        red_sub;
  logic signed [31:0] r0, r1, r2;
  logic               fold_flip;
  logic signed [35:0] dx, dy;
  logic signed [31:0] at;
  logic signed [35:0] vx, vy;
  logic signed [33:0] h0, h1;
  logic               sample_ok;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign cnt_in[0] = count_x_i;
  assign cnt_in[1] = count_y_i;
  assign cnt_in[2] = count_z_i;

  always_comb begin
    for (int k = 0; k < tcch_pkg::AXES; k++) begin
      cnt_neg[k] = neg_q[k] ? -{cnt_in[k][15], cnt_in[k]} : {cnt_in[k][15], cnt_in[k]};
      oor[k]     = (cnt_neg[k] > tcch_pkg::LIMIT_HIGH) || (cnt_neg[k] < tcch_pkg::LIMIT_LOW);
    end
  end

  assign axis      = cmd_i.step[1:0];
  assign sample_ok = bus_ok_q && (sat_q == 3'b000);
  assign stat_o.sample_ok = sample_ok;
  assign stat_o.zero_vec  = (hx_q == 32'sd0) && (hy_q == 32'sd0);

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (cmd_i.op)
      tcch_pkg::OP_AXIS: begin
        mul_a = {{20{cnt_q[axis][11]}}, cnt_q[axis]};
        mul_b = {1'b0, gain_q};
      end
      tcch_pkg::OP_P_MXCP: begin
        mul_a = fld_q[0];
        mul_b = cp_q;
      end
      tcch_pkg::OP_P_SRMY: begin
        mul_a = sr_q;
        mul_b = fld_q[1];
      end
      tcch_pkg::OP_P_PRSP: begin
        mul_a = pr_q;
        mul_b = sp_q;
      end
      tcch_pkg::OP_P_CRMZ: begin
        mul_a = cr_q;
        mul_b = fld_q[2];
      end
      tcch_pkg::OP_P_MYCR: begin
        mul_a = fld_q[1];
        mul_b = cr_q;
      end
      tcch_pkg::OP_P_MZSR: begin
        mul_a = fld_q[2];
        mul_b = sr_q;
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_sh  = prod[63:24];
  assign fm       = ((prod_sh[39:31] == 9'h000) || (prod_sh[39:31] == 9'h1ff)) ? prod_sh[31:0] :
                    (prod_sh[39] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign axis_sum = prod[31:0] + ofs_q[axis];

  // angle reduction and fold
  assign ang     = cmd_i.sel ? pitch_q : roll_q;
  assign red_sh  = 3'(3'(tcch_pkg::RED_STEPS - 1) - cmd_i.step[2:0]);
  assign red_sub = 32'(tcch_pkg::TWO_PI_RAW) << red_sh;

  always_comb begin
    r0 = neg_a_q ? -$signed(m_q) : $signed(m_q);
    if (r0 > tcch_pkg::PI_RAW) begin
      r1 = r0 - tcch_pkg::TWO_PI_RAW;
    end else if (r0 < -tcch_pkg::PI_RAW) begin
      r1 = r0 + tcch_pkg::TWO_PI_RAW;
    end else begin
      r1 = r0;
    end
    fold_flip = 1'b0;
    if (r1 > tcch_pkg::HALF_PI_RAW) begin
      r2        = tcch_pkg::PI_RAW - r1;
      fold_flip = 1'b1;
    end else if (r1 < -tcch_pkg::HALF_PI_RAW) begin
      r2        = -tcch_pkg::PI_RAW - r1;
      fold_flip = 1'b1;
    end else begin
      r2 = r1;
    end
  end

  assign dx = cy_q >>> cmd_i.step;
  assign dy = cx_q >>> cmd_i.step;
  assign at = $signed(tcch_pkg::atan_entry(cmd_i.step));
  assign vx = {{4{hx_q[31]}}, hx_q};
  assign vy = -{{4{hy_q[31]}}, hy_q};

  always_comb begin
    h0 = {{2{cz_q[31]}}, cz_q} - {{2{decl_q[31]}}, decl_q};
    if (h0 < -34'(tcch_pkg::PI_RAW)) begin
      h1 = h0 + 34'(tcch_pkg::TWO_PI_RAW);
    end else if (h0 > 34'(tcch_pkg::PI_RAW)) begin
      h1 = h0 - 34'(tcch_pkg::TWO_PI_RAW);
    end else begin
      h1 = h0;
    end
  end

  // config registers and stored fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      decl_q <= '0;
      neg_q  <= '0;
      for (int k = 0; k < tcch_pkg::AXES; k++) begin
        ofs_q[k] <= '0;
        fld_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcch_pkg::CFG_GAIN:     gain_q   <= cfg_data_i[30:0];
          tcch_pkg::CFG_OFS_X:    ofs_q[0] <= cfg_data_i;
          tcch_pkg::CFG_OFS_Y:    ofs_q[1] <= cfg_data_i;
          tcch_pkg::CFG_OFS_Z:    ofs_q[2] <= cfg_data_i;
          tcch_pkg::CFG_DECL:     decl_q   <= cfg_data_i;
          tcch_pkg::CFG_NEG_MASK: neg_q    <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cmd_i.op == tcch_pkg::OP_AXIS && bus_ok_q && !sat_q[axis]) begin
        fld_q[axis] <= axis_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_ok_q    <= 1'b0;
      sat_q       <= '0;
      valid_out_q <= 1'b0;
      sat_out_q   <= '0;
    end else begin
      if (cmd_i.op == tcch_pkg::OP_LOAD) begin
        bus_ok_q <= bus_ok_i;
        sat_q    <= bus_ok_i ? oor : 3'b000;
      end
      if (cmd_i.op == tcch_pkg::OP_FINAL) begin
        valid_out_q <= sample_ok;
        sat_out_q   <= sat_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tcch_pkg::OP_LOAD: begin
        for (int k = 0; k < tcch_pkg::AXES; k++) begin
          cnt_q[k] <= cnt_neg[k][11:0];
        end
        roll_q  <= roll_angle_i;
        pitch_q <= pitch_angle_i;
      end
      tcch_pkg::OP_RED_INIT: begin
        neg_a_q <= ang[31];
        m_q     <= ang[31] ? 32'd0 - ang : ang;
      end
      tcch_pkg::OP_RED_STEP: begin
        if (m_q >= red_sub) begin
          m_q <= m_q - red_sub;
        end
      end
      tcch_pkg::OP_FOLD: begin
        flip_q <= fold_flip;
        cx_q   <= 36'(tcch_pkg::CORDIC_GAIN_RAW);
        cy_q   <= '0;
        cz_q   <= r2;
      end
      tcch_pkg::OP_ROT: begin
        if (!cz_q[31]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end
      end
      tcch_pkg::OP_SAVE: begin
        if (cmd_i.sel) begin
          sp_q <= cy_q[31:0];
          cp_q <= flip_q ? -cx_q[31:0] : cx_q[31:0];
        end else begin
          sr_q <= cy_q[31:0];
          cr_q <= flip_q ? -cx_q[31:0] : cx_q[31:0];
        end
      end
      tcch_pkg::OP_P_MXCP, tcch_pkg::OP_P_SRMY, tcch_pkg::OP_P_PRSP,
      tcch_pkg::OP_P_CRMZ, tcch_pkg::OP_P_MYCR, tcch_pkg::OP_P_MZSR: begin
        pr_q <= fm;
      end
      tcch_pkg::OP_HX_SET: hx_q <= pr_q;
      tcch_pkg::OP_HX_ADD: hx_q <= sat33({hx_q[31], hx_q} + {pr_q[31], pr_q});
      tcch_pkg::OP_HY_SET: hy_q <= pr_q;
      tcch_pkg::OP_HY_SUB: hy_q <= sat33({hy_q[31], hy_q} - {pr_q[31], pr_q});
      tcch_pkg::OP_VPREP: begin
        if (vx < 0) begin
          cz_q <= (vy >= 0) ? tcch_pkg::PI_RAW : -tcch_pkg::PI_RAW;
          cx_q <= -vx;
          cy_q <= -vy;
        end else begin
          cz_q <= '0;
          cx_q <= vx;
          cy_q <= vy;
        end
      end
      tcch_pkg::OP_VEC: begin
        if (cy_q < 0) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end
      end
      tcch_pkg::OP_FINAL: begin
        fx_out_q   <= fld_q[0];
        fy_out_q   <= fld_q[1];
        fz_out_q   <= fld_q[2];
        head_out_q <= sample_ok ? h1[31:0] : tcch_pkg::INVALID_HEADING;
      end
      default: ;
    endcase
  end

  assign field_x_o        = fx_out_q;
  assign field_y_o        = fy_out_q;
  assign field_z_o        = fz_out_q;
  assign heading_angle_o  = head_out_q;
  assign sample_valid_o   = valid_out_q;
  assign saturated_axes_o = sat_out_q;

endmodule

// ===== design/tcch_ctrl.sv =====
// controller: sequences the datapath and runs the beat handshakes
module tcch_ctrl #(
  parameter int CORDIC_STEPS = tcch_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  tcch_pkg::dp_stat_t stat_i,
  output tcch_pkg::dp_cmd_t  cmd_o
);

  localparam int CW = $clog2(CORDIC_STEPS);

  tcch_pkg::state_e state_q, state_d;
  logic [CW-1:0]    step_q, step_d;
  logic             sel_q, sel_d;
  logic             out_valid_q, out_valid_d;
  logic             fire;

  assign fire = (state_q == tcch_pkg::ST_FINAL) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      tcch_pkg::ST_IDLE: begin
        sel_d = 1'b0;
        if (in_valid_i) begin
          state_d = tcch_pkg::ST_AXIS;
        end
      end
      tcch_pkg::ST_AXIS: begin
        if (step_q == CW'(tcch_pkg::AXES - 1)) begin
          state_d = stat_i.sample_ok ? tcch_pkg::ST_RED_INIT : tcch_pkg::ST_FINAL;
        end
      end
      tcch_pkg::ST_RED_INIT: state_d = tcch_pkg::ST_RED;
      tcch_pkg::ST_RED: begin
        if (step_q == CW'(tcch_pkg::RED_STEPS - 1)) begin
          state_d = tcch_pkg::ST_FOLD;
        end
      end
      tcch_pkg::ST_FOLD: state_d = tcch_pkg::ST_ROT;
      tcch_pkg::ST_ROT: begin
        if (step_q == CW'(CORDIC_STEPS - 1)) begin
          state_d = tcch_pkg::ST_SAVE;
        end
      end
      tcch_pkg::ST_SAVE: begin
        if (sel_q) begin
          state_d = tcch_pkg::ST_MATH;
        end else begin
          sel_d   = 1'b1;
          state_d = tcch_pkg::ST_RED_INIT;
        end
      end
      tcch_pkg::ST_MATH: begin
        if (step_q == CW'(tcch_pkg::MATH_OPS - 1)) begin
          state_d = tcch_pkg::ST_VPREP;
        end
      end
      tcch_pkg::ST_VPREP: state_d = stat_i.zero_vec ? tcch_pkg::ST_FINAL : tcch_pkg::ST_VEC;
      tcch_pkg::ST_VEC: begin
        if (step_q == CW'(CORDIC_STEPS - 1)) begin
          state_d = tcch_pkg::ST_FINAL;
        end
      end
      tcch_pkg::ST_FINAL: begin
        if (fire) begin
          state_d = tcch_pkg::ST_IDLE;
        end
      end
      default: state_d = tcch_pkg::ST_IDLE;
    endcase
    step_d      = (state_d != state_q || state_q == tcch_pkg::ST_IDLE) ? '0 : step_q + 1'b1;
    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  always_comb begin
    cmd_o.step = tcch_pkg::STEP_W'(step_q);
    cmd_o.sel  = sel_q;
    case (state_q)
      tcch_pkg::ST_IDLE:     cmd_o.op = in_valid_i ? tcch_pkg::OP_LOAD : tcch_pkg::OP_NONE;
      tcch_pkg::ST_AXIS:     cmd_o.op = tcch_pkg::OP_AXIS;
      tcch_pkg::ST_RED_INIT: cmd_o.op = tcch_pkg::OP_RED_INIT;
      tcch_pkg::ST_RED:      cmd_o.op = tcch_pkg::OP_RED_STEP;
      tcch_pkg::ST_FOLD:     cmd_o.op = tcch_pkg::OP_FOLD;
      tcch_pkg::ST_ROT:      cmd_o.op = tcch_pkg::OP_ROT;
      tcch_pkg::ST_SAVE:     cmd_o.op = tcch_pkg::OP_SAVE;
      tcch_pkg::ST_MATH:     cmd_o.op = tcch_pkg::math_op(step_q[3:0]);
      tcch_pkg::ST_VPREP:    cmd_o.op = tcch_pkg::OP_VPREP;
      tcch_pkg::ST_VEC:      cmd_o.op = tcch_pkg::OP_VEC;
      tcch_pkg::ST_FINAL:    cmd_o.op = fire ? tcch_pkg::OP_FINAL : tcch_pkg::OP_NONE;
      default:               cmd_o.op = tcch_pkg::OP_NONE;
    endcase
    in_stall_o  = (state_q != tcch_pkg::ST_IDLE);
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcch_pkg::ST_IDLE;
      step_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/tilt_compensated_compass_heading.sv =====
// top level of the tilt compensated compass heading block
// Input channel: one beat carries a magnetometer sample (bus_ok, three axis
// counts) with roll and pitch. The block takes a beat only while idle; it
// holds in_stall_o high while a sample is being worked on.
// Output channel: one beat per sample with the stored fields, heading,
// sample_valid and saturated_axes, held in an output register until taken.
// A finished result may wait there while the next sample is already taken.
// A sample with a bad bus or a saturated axis goes from the axis steps
// straight to the output beat. A valid sample is worked on by one shared
// cordic unit that runs sine/cosine for roll, then pitch, then atan2, and
// one shared 32x32 multiplier for the seven tilt products.
// The block takes no new sample before it is through with the last; the
// next sample is taken in the idle cycle right after the result is loaded.
// Configuration writes take effect in the next cycle; they are to be made
// only while idle, which the block itself does not enforce.
// Reset clears config registers, stored fields and all handshake state.
// A stalled receiver keeps the result on the port; the next sample then
// waits in the last step until the output register frees up.
module tilt_compensated_compass_heading #(
  parameter int CORDIC_STEPS = tcch_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            bus_ok_i,
  input  logic signed [15:0]              count_x_i,
  input  logic signed [15:0]              count_y_i,
  input  logic signed [15:0]              count_z_i,
  input  logic signed [31:0]              roll_angle_i,
  input  logic signed [31:0]              pitch_angle_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              field_x_o,
  output logic signed [31:0]              field_y_o,
  output logic signed [31:0]              field_z_o,
  output logic signed [31:0]              heading_angle_o,
  output logic                            sample_valid_o,
  output logic [2:0]                      saturated_axes_o,
  input  logic                            cfg_we_i,
  input  logic [tcch_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcch_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tcch_pkg::dp_cmd_t  cmd;
  tcch_pkg::dp_stat_t stat;

  tcch_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcch_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .bus_ok_i        (bus_ok_i),
    .count_x_i       (count_x_i),
    .count_y_i       (count_y_i),
    .count_z_i       (count_z_i),
    .roll_angle_i    (roll_angle_i),
    .pitch_angle_i   (pitch_angle_i),
    .field_x_o       (field_x_o),
    .field_y_o       (field_y_o),
    .field_z_o       (field_z_o),
    .heading_angle_o (heading_angle_o),
    .sample_valid_o  (sample_valid_o),
    .saturated_axes_o(saturated_axes_o)
  );

endmodule

// ===== design/tcch_checker.sv =====
// port level checks for the compass heading block, bound to the top level
module tcch_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] heading_angle_o,
  input logic               sample_valid_o,
  input logic [2:0]         saturated_axes_o
);

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heading_angle_o))
    else $error("stalled output beat changed");

  a_invalid_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> heading_angle_o == tcch_pkg::INVALID_HEADING)
    else $error("invalid sample without invalid heading");

  a_valid_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> saturated_axes_o == 3'b000)
    else $error("valid sample with saturated axis");

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .heading_angle_o (heading_angle_o),
  .sample_valid_o  (sample_valid_o),
  .saturated_axes_o(saturated_axes_o)
);
